// File: rtl/core/kslt_pkg.sv
// Shared types and constants for the key short-press LED toggle core.
// No dependencies; imported by every module in rtl/core.
package kslt_pkg;

  localparam int unsigned NUM_KEYS = 4;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_SHORT_LIMIT = 2'd0;
  localparam logic [1:0] REG_MAX_LIMIT   = 2'd1;
  localparam logic [1:0] REG_LINK_MASK   = 2'd2;

  localparam logic [TICK_W-1:0]   SHORT_LIMIT_RST = 8'd3;
  localparam logic [TICK_W-1:0]   MAX_LIMIT_RST   = 8'd255;
  localparam logic [NUM_KEYS-1:0] LINK_MASK_RST   = 4'd0;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_SHORT  = 4'b0100,
    PH_EXPORT = 4'b1000
  } key_phase_e;

  // Per-channel LED/export event for one scan tick
  typedef struct packed {
    logic led_clr;
    logic led_tgl;
    logic export_req;
  } chan_evt_t;

  typedef struct packed {
    logic [TICK_W-1:0]   short_limit;
    logic [TICK_W-1:0]   max_limit;
    logic [NUM_KEYS-1:0] link_mask;
  } cfg_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] led_bits;
    logic [NUM_KEYS-1:0] export_bits;
  } result_t;

endpackage

// File: rtl/core/key_short_press_led_toggle_core.sv
// Key short-press LED toggle core: one phase machine per key channel.
// Latency: a result is valid the cycle after acceptance into a free head slot.
// Throughput: one scan request per cycle while in_ready_o is high; the
//   two-entry buffer keeps it high while a single result waits downstream.
// Reset (rst_ni low, asynchronous): all channels idle, counters and LEDs
//   cleared, registers at short_limit=3, max_limit=255, link_mask=0.
module key_short_press_led_toggle_core
  import kslt_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // scan request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NUM_KEYS-1:0] key_bits_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [NUM_KEYS-1:0] led_bits_o,
  output logic [NUM_KEYS-1:0] export_bits_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t                cfg;
  logic                accept;
  logic                space;
  chan_evt_t           evt [CHANNELS];
  logic [NUM_KEYS-1:0] led_q, led_d;
  logic [NUM_KEYS-1:0] export_vec;
  result_t             res_in, res_out;

  // Registers
  kslt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Accept whenever the result buffer has a free slot
  assign in_ready_o = space;
  assign accept     = in_valid_i & space;

  // One phase machine per populated channel; all advance on the same request
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    kslt_chan u_chan (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .step_i        (accept),
      .key_i         (key_bits_i[ch]),
      .link_i        (cfg.link_mask[ch]),
      .short_limit_i (cfg.short_limit),
      .max_limit_i   (cfg.max_limit),
      .evt_o         (evt[ch])
    );
  end

  // Fold channel events into the LED image and export vector.
  // Unpopulated channels hold their LED bit and never export.
  always_comb begin
    led_d      = led_q;
    export_vec = '0;
    for (int unsigned ch = 0; ch < CHANNELS; ch++) begin
      if (evt[ch].led_clr) led_d[ch] = 1'b0;
      if (evt[ch].led_tgl) led_d[ch] = ~led_q[ch];
      export_vec[ch] = evt[ch].export_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else if (accept) begin
      led_q <= led_d;
    end
  end

  assign res_in.led_bits    = led_d;
  assign res_in.export_bits = export_vec;

  // Result register with skid slot
  kslt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res_in),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (res_out)
  );

  assign led_bits_o    = res_out.led_bits;
  assign export_bits_o = res_out.export_bits;

`ifndef SYNTH
  // A full buffer always shows a result downstream
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A request taken into an empty buffer shows up next cycle
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  // Unpopulated channels never export
  a_no_export_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((export_bits_o >> CHANNELS) == '0))
    else $error("export from unpopulated channel");

  // LED image moves only on an accepted request
  a_led_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(led_q))
    else $error("LED state changed without a request");
`endif

endmodule

// File: rtl/core/kslt_cfg.sv
// Configuration register file with an APB-style write/read port.
// Depends on kslt_pkg for register indexes and reset values.
module kslt_cfg
  import kslt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [1:0] reg_idx;
  logic       wr_en;
  cfg_t       cfg_q;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_limit <= SHORT_LIMIT_RST;
      cfg_q.max_limit   <= MAX_LIMIT_RST;
      cfg_q.link_mask   <= LINK_MASK_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SHORT_LIMIT: cfg_q.short_limit <= pwdata[TICK_W-1:0];
        REG_MAX_LIMIT:   cfg_q.max_limit   <= pwdata[TICK_W-1:0];
        REG_LINK_MASK:   cfg_q.link_mask   <= pwdata[NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SHORT_LIMIT: prdata[TICK_W-1:0]   = cfg_q.short_limit;
      REG_MAX_LIMIT:   prdata[TICK_W-1:0]   = cfg_q.max_limit;
      REG_LINK_MASK:   prdata[NUM_KEYS-1:0] = cfg_q.link_mask;
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/kslt_chan.sv
// One key channel: press counter and phase machine, advanced once per request.
// Depends on kslt_pkg for the phase enum and event struct.
module kslt_chan
  import kslt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              key_i,
  input  logic              link_i,
  input  logic [TICK_W-1:0] short_limit_i,
  input  logic [TICK_W-1:0] max_limit_i,
  output chan_evt_t         evt_o
);

  key_phase_e        phase_q, phase_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    evt_o   = '0;
    case (phase_q)
      PH_IDLE: begin
        if (key_i) begin
          ticks_d = TICK_W'(1);
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (key_i) begin
          if (ticks_q < max_limit_i) ticks_d = ticks_q + TICK_W'(1);
        end else begin
          // drop presses that are too short
          phase_d = (ticks_q < short_limit_i) ? PH_IDLE : PH_SHORT;
          ticks_d = '0;
        end
      end
      PH_SHORT: begin
        if (!key_i) begin
          if (link_i) begin
            evt_o.led_tgl = 1'b1;
            phase_d       = PH_EXPORT;
          end else begin
            evt_o.led_clr = 1'b1;
            phase_d       = PH_IDLE;
          end
        end
      end
      PH_EXPORT: begin
        if (!key_i) begin
          evt_o.export_req = 1'b1;
          phase_d          = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        ticks_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ticks_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

// File: rtl/core/kslt_out.sv
// Two-entry result buffer (head register plus skid register).
// Depends on kslt_pkg for the result struct.
module kslt_out
  import kslt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t data_o
);

  logic    head_vld_q, head_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop         = head_vld_q & out_ready_i;
  assign space_o     = ~skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign data_o      = head_q;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      head_vld_d = skid_vld_q;
      head_d     = skid_q;
      skid_vld_d = 1'b0;
    end
    if (push_i) begin
      if (!head_vld_d) begin
        head_vld_d = 1'b1;
        head_d     = data_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule
